// File: design/word_stream_mix_hash_assert.svh
// Assertion macros for the word_stream_mix_hash checker.
`ifndef WORD_STREAM_MIX_HASH_ASSERT_SVH
`define WORD_STREAM_MIX_HASH_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSMH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("word_stream_mix_hash: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WSMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("word_stream_mix_hash: check failed");

`endif

// File: design/wsmh_pkg.sv
// Package for the word stream mix hash: constants, control word types and microcode ROM.
`timescale 1ns / 1ps

package wsmh_pkg;

    // Mixing constants
    localparam logic [63:0] GOLDEN  = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] FIN_M1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] FIN_M2  = 64'h94D049BB133111EB;
    localparam logic [63:0] CHAIN_M = 64'h3C79AC492BA7B653;
    localparam logic [63:0] TAIL_K  = 64'h1C69B3F74AC4AE35;
    localparam logic [63:0] AVA_M1  = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] AVA_M2  = 64'hC4CEB9FE1A85EC53;

    // Datapath operations
    localparam logic [3:0] OP_NOP      = 4'd0;
    localparam logic [3:0] OP_LD_SEED  = 4'd1;  // acc = seed ^ length
    localparam logic [3:0] OP_LD_WORD  = 4'd2;  // acc = word + golden
    localparam logic [3:0] OP_LD_TAIL  = 4'd3;  // acc = tail ^ tail constant
    localparam logic [3:0] OP_XSR      = 4'd4;  // acc ^= acc >> shift
    localparam logic [3:0] OP_MUL_LL   = 4'd5;  // prod = a_lo * k_lo
    localparam logic [3:0] OP_MUL_LH   = 4'd6;  // prod.hi += a_lo * k_hi
    localparam logic [3:0] OP_MUL_HL   = 4'd7;  // acc = prod + (a_hi * k_lo) << 32
    localparam logic [3:0] OP_MIX      = 4'd8;  // acc = rotl(chain ^ acc, 27)
    localparam logic [3:0] OP_XCH      = 4'd9;  // acc = chain ^ acc
    localparam logic [3:0] OP_ST_CHAIN = 4'd10; // chain = acc

    // Shift selects
    localparam logic [1:0] SH_30 = 2'd0;
    localparam logic [1:0] SH_27 = 2'd1;
    localparam logic [1:0] SH_31 = 2'd2;
    localparam logic [1:0] SH_33 = 2'd3;

    // Multiplier constant selects
    localparam logic [2:0] K_FIN1  = 3'd0;
    localparam logic [2:0] K_FIN2  = 3'd1;
    localparam logic [2:0] K_CHAIN = 3'd2;
    localparam logic [2:0] K_AVA1  = 3'd3;
    localparam logic [2:0] K_AVA2  = 3'd4;

    // Sequencer conditions
    localparam logic [2:0] C_NEXT        = 3'd0; // fall through
    localparam logic [2:0] C_SHORTLAST   = 3'd1; // jump if last beat is short
    localparam logic [2:0] C_NOTLAST_END = 3'd2; // finish quietly if not last
    localparam logic [2:0] C_END         = 3'd3; // finish and emit result
    localparam logic [2:0] C_STOP        = 3'd4; // finish quietly

    // Program entry points
    localparam logic [5:0] UA_SEED = 6'd0;
    localparam logic [5:0] UA_BODY = 6'd11;
    localparam logic [5:0] UA_TAIL = 6'd26;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] shift_sel;
        logic [2:0] k_sel;
    } dp_ctrl_t;

    typedef struct packed {
        dp_ctrl_t   dp;
        logic [2:0] cond;
        logic [5:0] target;
    } ucode_t;

    function automatic ucode_t uw(input logic [3:0] op, input logic [1:0] sh,
                                  input logic [2:0] k, input logic [2:0] cond,
                                  input logic [5:0] target);
        ucode_t u;
        u.dp.op        = op;
        u.dp.shift_sel = sh;
        u.dp.k_sel     = k;
        u.cond         = cond;
        u.target       = target;
        return u;
    endfunction

    // Microcode ROM
    function automatic ucode_t wsmh_ucode(input logic [5:0] addr);
        ucode_t u;
        u = uw(OP_NOP, SH_30, K_FIN1, C_STOP, UA_SEED);
        case (addr)
            // start of message: chain = finalize(seed ^ length)
            6'd0:  u = uw(OP_LD_SEED,  SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd1:  u = uw(OP_XSR,      SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd2:  u = uw(OP_MUL_LL,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd3:  u = uw(OP_MUL_LH,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd4:  u = uw(OP_MUL_HL,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd5:  u = uw(OP_XSR,      SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd6:  u = uw(OP_MUL_LL,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd7:  u = uw(OP_MUL_LH,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd8:  u = uw(OP_MUL_HL,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd9:  u = uw(OP_XSR,      SH_31, K_FIN2,  C_NEXT, UA_SEED);
            6'd10: u = uw(OP_ST_CHAIN, SH_31, K_FIN2,  C_NEXT, UA_SEED);
            // word body: short last beat skips to the tail
            6'd11: u = uw(OP_LD_WORD,  SH_30, K_FIN1,  C_SHORTLAST, UA_TAIL);
            6'd12: u = uw(OP_XSR,      SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd13: u = uw(OP_MUL_LL,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd14: u = uw(OP_MUL_LH,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd15: u = uw(OP_MUL_HL,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd16: u = uw(OP_XSR,      SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd17: u = uw(OP_MUL_LL,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd18: u = uw(OP_MUL_LH,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd19: u = uw(OP_MUL_HL,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd20: u = uw(OP_XSR,      SH_31, K_FIN2,  C_NEXT, UA_SEED);
            6'd21: u = uw(OP_MIX,      SH_31, K_CHAIN, C_NEXT, UA_SEED);
            6'd22: u = uw(OP_MUL_LL,   SH_31, K_CHAIN, C_NEXT, UA_SEED);
            6'd23: u = uw(OP_MUL_LH,   SH_31, K_CHAIN, C_NEXT, UA_SEED);
            6'd24: u = uw(OP_MUL_HL,   SH_31, K_CHAIN, C_NEXT, UA_SEED);
            6'd25: u = uw(OP_ST_CHAIN, SH_31, K_CHAIN, C_NOTLAST_END, UA_SEED);
            // tail and avalanche
            6'd26: u = uw(OP_LD_TAIL,  SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd27: u = uw(OP_XSR,      SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd28: u = uw(OP_MUL_LL,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd29: u = uw(OP_MUL_LH,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd30: u = uw(OP_MUL_HL,   SH_30, K_FIN1,  C_NEXT, UA_SEED);
            6'd31: u = uw(OP_XSR,      SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd32: u = uw(OP_MUL_LL,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd33: u = uw(OP_MUL_LH,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd34: u = uw(OP_MUL_HL,   SH_27, K_FIN2,  C_NEXT, UA_SEED);
            6'd35: u = uw(OP_XSR,      SH_31, K_FIN2,  C_NEXT, UA_SEED);
            6'd36: u = uw(OP_XCH,      SH_33, K_AVA1,  C_NEXT, UA_SEED);
            6'd37: u = uw(OP_XSR,      SH_33, K_AVA1,  C_NEXT, UA_SEED);
            6'd38: u = uw(OP_MUL_LL,   SH_33, K_AVA1,  C_NEXT, UA_SEED);
            6'd39: u = uw(OP_MUL_LH,   SH_33, K_AVA1,  C_NEXT, UA_SEED);
            6'd40: u = uw(OP_MUL_HL,   SH_33, K_AVA1,  C_NEXT, UA_SEED);
            6'd41: u = uw(OP_XSR,      SH_33, K_AVA2,  C_NEXT, UA_SEED);
            6'd42: u = uw(OP_MUL_LL,   SH_33, K_AVA2,  C_NEXT, UA_SEED);
            6'd43: u = uw(OP_MUL_LH,   SH_33, K_AVA2,  C_NEXT, UA_SEED);
            6'd44: u = uw(OP_MUL_HL,   SH_33, K_AVA2,  C_NEXT, UA_SEED);
            6'd45: u = uw(OP_XSR,      SH_33, K_AVA2,  C_NEXT, UA_SEED);
            6'd46: u = uw(OP_ST_CHAIN, SH_33, K_AVA2,  C_END,  UA_SEED);
            default: u = uw(OP_NOP,    SH_30, K_FIN1,  C_STOP, UA_SEED);
        endcase
        return u;
    endfunction

endpackage

// File: design/wsmh_datapath.sv
// Hash datapath: accumulator, shared 32x32 multiplier, chain register.
`timescale 1ns / 1ps

module wsmh_datapath
    import wsmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_ctrl_t    ctrl,
    input  logic [63:0] seed,
    input  logic [63:0] length,
    input  logic [63:0] word,
    input  logic        tail_word,
    output logic [63:0] acc
);

    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [63:0] chain_reg;
    logic [63:0] chain_next;
    logic [63:0] k_val;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;
    logic [63:0] xsr_val;
    logic [63:0] mix_val;

    // Multiplier constant select
    always_comb
    begin
        case (ctrl.k_sel)
            K_FIN1:  k_val = FIN_M1;
            K_FIN2:  k_val = FIN_M2;
            K_CHAIN: k_val = CHAIN_M;
            K_AVA1:  k_val = AVA_M1;
            K_AVA2:  k_val = AVA_M2;
            default: k_val = FIN_M1;
        endcase
    end

    // One 32x32 multiplier, three passes give the low 64 bits of a 64x64 product
    assign mul_a   = (ctrl.op == OP_MUL_HL) ? acc_reg[63:32] : acc_reg[31:0];
    assign mul_b   = (ctrl.op == OP_MUL_LH) ? k_val[63:32] : k_val[31:0];
    assign product = 64'(mul_a) * 64'(mul_b);

    // xor-shift with fixed shift amounts
    always_comb
    begin
        case (ctrl.shift_sel)
            SH_30:   xsr_val = acc_reg ^ (acc_reg >> 30);
            SH_27:   xsr_val = acc_reg ^ (acc_reg >> 27);
            SH_31:   xsr_val = acc_reg ^ (acc_reg >> 31);
            default: xsr_val = acc_reg ^ (acc_reg >> 33);
        endcase
    end

    assign mix_val = chain_reg ^ acc_reg;

    // Operation decoder
    always_comb
    begin
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        chain_next = chain_reg;
        unique case (ctrl.op)
            OP_NOP:      acc_next = acc_reg;
            OP_LD_SEED:  acc_next = seed ^ length;
            OP_LD_WORD:  acc_next = word + GOLDEN;
            OP_LD_TAIL:  acc_next = (tail_word ? word : 64'd0) ^ TAIL_K;
            OP_XSR:      acc_next = xsr_val;
            OP_MUL_LL:   prod_next = product;
            OP_MUL_LH:   prod_next = {prod_reg[63:32] + product[31:0], prod_reg[31:0]};
            OP_MUL_HL:   acc_next = {prod_reg[63:32] + product[31:0], prod_reg[31:0]};
            OP_MIX:      acc_next = {mix_val[36:0], mix_val[63:37]};
            OP_XCH:      acc_next = mix_val;
            OP_ST_CHAIN: chain_next = acc_reg;
            default:     acc_next = acc_reg;
        endcase
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

    // Chain state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign acc = acc_reg;

endmodule

// File: design/word_stream_mix_hash.sv
// Top level of the word stream mix hash: stream ports, byte counting, microcode sequencer.
`timescale 1ns / 1ps

// Keyed 64-bit hash over little-endian 64-bit word beats. A beat with tuser set starts a
// message and samples its length; the beat with tlast set ends it and yields one result
// beat carrying the hash and a length error flag. One beat is processed at a time by a
// microcoded sequence over a single shared 32x32 multiplier (three passes per 64-bit
// product); a middle word runs the body steps, a starting beat the seed steps first, a
// short last beat loads and jumps to the tail steps, a full last beat body and tail. The
// input is ready again as soon as the sequence ends; a finished result waits in the
// output register while the next beat is taken. hash_seed must be written on the cfg
// channel only while no message beat is in flight; the block itself does not enforce it.
module word_stream_mix_hash
    import wsmh_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration: hash_seed
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [63:0]  cfg_data,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // word_data[63:0], byte_count[67:64],
                                         // message_length[99:68], zero pad
    input  logic         s_axis_tuser,   // first_word
    input  logic         s_axis_tlast,   // last_word
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // hash_value[63:0]
    output logic         m_axis_tuser    // length_error
);

    localparam int SUM_W = LENGTH_BITS + 1;

    logic                   busy_reg;
    logic [5:0]             pc_reg;
    logic [63:0]            seed_reg;
    logic [63:0]            word_reg;
    logic                   short_reg;
    logic                   last_reg;
    logic [LENGTH_BITS-1:0] bytes_reg;
    logic [LENGTH_BITS-1:0] bytes_next;
    logic [LENGTH_BITS-1:0] decl_reg;
    logic [LENGTH_BITS-1:0] decl_next;
    logic                   fault_reg;
    logic                   fault_next;
    logic                   err_reg;
    logic                   out_valid_reg;
    logic [63:0]            out_hash_reg;
    logic                   out_err_reg;

    logic [63:0]            in_word;
    logic [3:0]             in_count;
    logic                   in_first;
    logic                   in_last;
    logic [31:0]            in_length;
    logic [3:0]             n_bytes;
    logic                   in_short;
    logic [63:0]            masked_word;
    logic [LENGTH_BITS-1:0] base_bytes;
    logic [SUM_W-1:0]       byte_sum;
    logic                   accept;

    ucode_t                 uword;
    dp_ctrl_t               dp_ctrl;
    logic                   stall;
    logic                   step;
    logic [63:0]            acc;

    assign in_word   = s_axis_tdata[63:0];
    assign in_count  = s_axis_tdata[67:64];
    assign in_length = s_axis_tdata[99:68];
    assign in_first  = s_axis_tuser;
    assign in_last   = s_axis_tlast;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;
    assign cfg_ready     = 1'b1;

    // Saturate count to a full word, zero bytes past it
    assign n_bytes  = in_count[3] ? 4'd8 : in_count;
    assign in_short = !in_count[3];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            masked_word[i*8 +: 8] = (4'(i) < n_bytes) ? in_word[i*8 +: 8] : 8'd0;
        end
    end

    // Byte count with saturation, and length check
    always_comb
    begin
        decl_next  = in_first ? LENGTH_BITS'(in_length) : decl_reg;
        base_bytes = in_first ? '0 : bytes_reg;
        fault_next = in_first ? 1'b0 : fault_reg;
        byte_sum   = {1'b0, base_bytes} + SUM_W'(n_bytes);
        if (byte_sum[LENGTH_BITS])
        begin
            bytes_next = '1;
            fault_next = 1'b1;
        end
        else
        begin
            bytes_next = byte_sum[LENGTH_BITS-1:0];
        end
        if (!in_last && in_short)
        begin
            fault_next = 1'b1;
        end
    end

    // Sequencer control
    assign uword   = wsmh_ucode(pc_reg);
    assign stall   = (uword.cond == C_END) && out_valid_reg && !m_axis_tready;
    assign step    = busy_reg && !stall;
    assign dp_ctrl = step ? uword.dp : '{op: OP_NOP, shift_sel: SH_30, k_sel: K_FIN1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= UA_SEED;
            seed_reg      <= '0;
            bytes_reg     <= '0;
            decl_reg      <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                seed_reg <= cfg_data;
            end

            // result valid: set at the end of a sequence, cleared when taken
            if (step && (uword.cond == C_END))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                busy_reg  <= 1'b1;
                pc_reg    <= in_first ? UA_SEED : UA_BODY;
                bytes_reg <= bytes_next;
                decl_reg  <= decl_next;
                fault_reg <= fault_next;
            end
            else if (step)
            begin
                unique case (uword.cond)
                    C_NEXT:
                    begin
                        pc_reg <= pc_reg + 6'd1;
                    end
                    C_SHORTLAST:
                    begin
                        pc_reg <= (last_reg && short_reg) ? uword.target : pc_reg + 6'd1;
                    end
                    C_NOTLAST_END:
                    begin
                        if (last_reg)
                        begin
                            pc_reg <= pc_reg + 6'd1;
                        end
                        else
                        begin
                            busy_reg <= 1'b0;
                        end
                    end
                    C_END:
                    begin
                        busy_reg <= 1'b0;
                    end
                    default:
                    begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Beat payload and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg  <= masked_word;
            short_reg <= in_short;
            last_reg  <= in_last;
            err_reg   <= fault_next || (bytes_next != decl_next);
        end
        if (step && (uword.cond == C_END))
        begin
            out_hash_reg <= acc;
            out_err_reg  <= err_reg;
        end
    end

    wsmh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .seed      (seed_reg),
        .length    (64'(decl_reg)),
        .word      (word_reg),
        .tail_word (short_reg),
        .acc       (acc)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_hash_reg;
    assign m_axis_tuser  = out_err_reg;

endmodule

// File: design/wsmh_checker.sv
// Port-level checker for word_stream_mix_hash, bound to the top level.
`timescale 1ns / 1ps
`include "word_stream_mix_hash_assert.svh"

module wsmh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled result beat holds
    `WSMH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // One beat at a time: input closes after an accept
    `WSMH_ASSERT_NEXT(a_in_closes, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A result only appears at the end of a sequence
    `WSMH_ASSERT_NOW(a_out_after_work, $rose(m_axis_tvalid), $past(!s_axis_tready))

    // No result the cycle after an accept
    `WSMH_ASSERT_NEXT(a_no_instant_out, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

endmodule

bind word_stream_mix_hash wsmh_checker u_wsmh_checker (.*);
